// ===== design/iphu_pkg.sv =====
// Shared types and constants for the IPv4 post-routing header update unit.
package iphu_pkg;

    // Working store: six address bits, positions wrap at 64
    localparam int RAM_DEPTH = 64;
    localparam int RAM_AW    = 6;

    // Result verdict codes
    localparam logic [1:0] VERDICT_FWD   = 2'd0;
    localparam logic [1:0] VERDICT_BCAST = 2'd1;
    localparam logic [1:0] VERDICT_OPT   = 2'd2;
    localparam logic [1:0] VERDICT_TTL   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_ROUTER    = 3'd0;
    localparam logic [2:0] CFG_DROP_BC   = 3'd1;
    localparam logic [2:0] CFG_OPT_EN    = 3'd2;
    localparam logic [2:0] CFG_FIX_EN    = 3'd3;
    localparam logic [2:0] CFG_TTL_EN    = 3'd4;
    localparam logic [2:0] CFG_CKSUM_EN  = 3'd5;

    // IP option types
    localparam logic [7:0] OPT_END   = 8'd0;
    localparam logic [7:0] OPT_NOOP  = 8'd1;
    localparam logic [7:0] OPT_ROUTE = 8'd7;
    localparam logic [7:0] OPT_STAMP = 8'd68;

    // Timestamp flag modes and overflow limit
    localparam logic [3:0] TS_FLG_STAMP   = 4'd0;
    localparam logic [3:0] TS_FLG_ADDR    = 4'd1;
    localparam logic [3:0] TS_FLG_PRESPEC = 4'd3;
    localparam logic [3:0] OFLW_MAX       = 4'hF;

    localparam logic [26:0] DAY_MS       = 27'd86400000;
    localparam logic [15:0] TTL_CSUM_ADJ = 16'hFEFF;

    // Fixed header positions
    localparam logic [5:0] HDR_MIN  = 6'd20;
    localparam logic [5:0] POS_TTL  = 6'd8;
    localparam logic [5:0] POS_CSUM = 6'd10;
    localparam logic [5:0] POS_SRC  = 6'd12;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_BEGIN,
        OP_HLEN,
        OP_RD_TYPE,
        OP_GET_TYPE,
        OP_NOOP_STEP,
        OP_GET_LEN,
        OP_NEXT_OPT,
        OP_GET_PTR,
        OP_GET_OFL,
        OP_JOB_ROUTE,
        OP_JOB_TS0,
        OP_JOB_TS1,
        OP_JOB_TS3,
        OP_JOB_OFL,
        OP_JOB_FIX,
        OP_JOB_CK,
        OP_JOB_TTL,
        OP_JOB_INC,
        OP_WR,
        OP_SEQ_CMP,
        OP_SEQ_CK,
        OP_SEQ_TTL,
        OP_SEQ_OLD,
        OP_SEQ_RD,
        OP_SEQ_GET,
        OP_EM_START,
        OP_EM_RD,
        OP_EM_OUT,
        OP_DROP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] verdict;
    } t_cmd;

    typedef struct packed {
        logic       drop_bc;
        logic       opt_go;
        logic       oi_end;
        logic       is_noop;
        logic       is_end;
        logic       is_route;
        logic       is_stamp;
        logic       len_bad;
        logic       route_ok;
        logic       route_full;
        logic       p_bad;
        logic [3:0] flg;
        logic       room4;
        logic       room8;
        logic       ofl_ok;
        logic       cmp_eq;
        logic       fix_go;
        logic       changed;
        logic       ttl_en;
        logic       ttl_gt1;
        logic       ck_en;
        logic       job_done;
        logic       seq_done;
        logic       emit_last;
        logic       out_free;
    } t_status;

endpackage

// ===== design/iphu_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
module iphu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port, read data holds while read is idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== design/iphu_ctrl.sv =====
// Controller state machine: sequences load, option walk, source fix, checksum, TTL, emission and drop.
module iphu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_is_last_byte,
    input  iphu_pkg::t_status i_status,
    output iphu_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);
    import iphu_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD,
        S_BEGIN,
        S_HLEN,
        S_OPT_CHK,
        S_TYPE_RD,
        S_TYPE,
        S_LEN,
        S_LEN_CHK,
        S_PTR,
        S_ROUTE,
        S_OFL,
        S_TS,
        S_OVF,
        S_CMP_CHK,
        S_NEXT,
        S_SEQ_RD,
        S_SEQ_GET,
        S_WRITE,
        S_FIX,
        S_CK_CHK,
        S_CK_WR,
        S_TTL,
        S_TTL_CHK,
        S_OLD,
        S_INC,
        S_EM_START,
        S_EM_RD,
        S_EM_OUT,
        S_DROP
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [1:0] r_dv, n_dv;
    logic       r_in_stall;
    t_cmd       c_cmd;

    // next state and command
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_dv          = r_dv;
        c_cmd.op      = OP_IDLE;
        c_cmd.verdict = VERDICT_FWD;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    c_cmd.op = OP_LOAD;
                    if (i_is_last_byte) n_state = S_BEGIN;
                end
            end
            S_BEGIN: begin
                c_cmd.op = OP_BEGIN;
                if (i_status.drop_bc) begin
                    n_dv    = VERDICT_BCAST;
                    n_state = S_DROP;
                end else begin
                    n_state = S_HLEN;
                end
            end
            S_HLEN: begin
                c_cmd.op = OP_HLEN;
                n_state  = S_OPT_CHK;
            end
            S_OPT_CHK: begin
                n_state = i_status.opt_go ? S_TYPE_RD : S_FIX;
            end
            S_TYPE_RD: begin
                if (i_status.oi_end) begin
                    n_state = S_FIX;
                end else begin
                    c_cmd.op = OP_RD_TYPE;
                    n_state  = S_TYPE;
                end
            end
            S_TYPE: begin
                c_cmd.op = OP_GET_TYPE;
                n_state  = S_LEN;
            end
            S_LEN: begin
                priority if (i_status.is_noop) begin
                    c_cmd.op = OP_NOOP_STEP;
                    n_state  = S_TYPE_RD;
                end else if (i_status.is_end) begin
                    n_state = S_FIX;
                end else begin
                    c_cmd.op = OP_GET_LEN;
                    n_state  = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                priority if (i_status.len_bad) begin
                    n_dv    = VERDICT_OPT;
                    n_state = S_DROP;
                end else if (i_status.is_route || i_status.is_stamp) begin
                    n_state = S_PTR;
                end else begin
                    c_cmd.op = OP_NEXT_OPT;
                    n_state  = S_TYPE_RD;
                end
            end
            S_PTR: begin
                c_cmd.op = OP_GET_PTR;
                n_state  = i_status.is_route ? S_ROUTE : S_OFL;
            end
            S_ROUTE: begin
                priority if (i_status.route_ok) begin
                    c_cmd.op = OP_JOB_ROUTE;
                    n_ret    = S_NEXT;
                    n_state  = S_WRITE;
                end else if (i_status.route_full) begin
                    c_cmd.op = OP_NEXT_OPT;
                    n_state  = S_TYPE_RD;
                end else begin
                    n_dv    = VERDICT_OPT;
                    n_state = S_DROP;
                end
            end
            S_OFL: begin
                c_cmd.op = OP_GET_OFL;
                n_state  = S_TS;
            end
            S_TS: begin
                priority if (i_status.p_bad) begin
                    n_dv    = VERDICT_OPT;
                    n_state = S_DROP;
                end else if (i_status.flg == TS_FLG_STAMP) begin
                    if (i_status.room4) begin
                        c_cmd.op = OP_JOB_TS0;
                        n_ret    = S_NEXT;
                        n_state  = S_WRITE;
                    end else begin
                        n_state = S_OVF;
                    end
                end else if (i_status.flg == TS_FLG_ADDR) begin
                    if (i_status.room8) begin
                        c_cmd.op = OP_JOB_TS1;
                        n_ret    = S_NEXT;
                        n_state  = S_WRITE;
                    end else begin
                        n_state = S_OVF;
                    end
                end else if (i_status.flg == TS_FLG_PRESPEC && i_status.room8) begin
                    c_cmd.op = OP_SEQ_CMP;
                    n_ret    = S_CMP_CHK;
                    n_state  = S_SEQ_RD;
                end else begin
                    n_dv    = VERDICT_OPT;
                    n_state = S_DROP;
                end
            end
            S_OVF: begin
                if (i_status.ofl_ok) begin
                    c_cmd.op = OP_JOB_OFL;
                    n_ret    = S_NEXT;
                    n_state  = S_WRITE;
                end else begin
                    n_dv    = VERDICT_OPT;
                    n_state = S_DROP;
                end
            end
            S_CMP_CHK: begin
                if (i_status.cmp_eq) begin
                    c_cmd.op = OP_JOB_TS3;
                    n_ret    = S_NEXT;
                    n_state  = S_WRITE;
                end else begin
                    c_cmd.op = OP_NEXT_OPT;
                    n_state  = S_TYPE_RD;
                end
            end
            S_NEXT: begin
                c_cmd.op = OP_NEXT_OPT;
                n_state  = S_TYPE_RD;
            end
            S_SEQ_RD: begin
                if (i_status.seq_done) begin
                    n_state = r_ret;
                end else begin
                    c_cmd.op = OP_SEQ_RD;
                    n_state  = S_SEQ_GET;
                end
            end
            S_SEQ_GET: begin
                c_cmd.op = OP_SEQ_GET;
                n_state  = S_SEQ_RD;
            end
            S_WRITE: begin
                if (i_status.job_done) begin
                    n_state = r_ret;
                end else begin
                    c_cmd.op = OP_WR;
                end
            end
            S_FIX: begin
                if (i_status.fix_go) begin
                    c_cmd.op = OP_JOB_FIX;
                    n_ret    = S_CK_CHK;
                    n_state  = S_WRITE;
                end else begin
                    n_state = S_CK_CHK;
                end
            end
            S_CK_CHK: begin
                if (i_status.changed) begin
                    c_cmd.op = OP_SEQ_CK;
                    n_ret    = S_CK_WR;
                    n_state  = S_SEQ_RD;
                end else begin
                    n_state = S_TTL;
                end
            end
            S_CK_WR: begin
                c_cmd.op = OP_JOB_CK;
                n_ret    = S_TTL;
                n_state  = S_WRITE;
            end
            S_TTL: begin
                if (i_status.ttl_en) begin
                    c_cmd.op = OP_SEQ_TTL;
                    n_ret    = S_TTL_CHK;
                    n_state  = S_SEQ_RD;
                end else begin
                    n_state = S_EM_START;
                end
            end
            S_TTL_CHK: begin
                if (i_status.ttl_gt1) begin
                    c_cmd.op = OP_JOB_TTL;
                    n_ret    = S_OLD;
                    n_state  = S_WRITE;
                end else begin
                    n_dv    = VERDICT_TTL;
                    n_state = S_DROP;
                end
            end
            S_OLD: begin
                if (i_status.ck_en) begin
                    c_cmd.op = OP_SEQ_OLD;
                    n_ret    = S_INC;
                    n_state  = S_SEQ_RD;
                end else begin
                    n_state = S_EM_START;
                end
            end
            S_INC: begin
                c_cmd.op = OP_JOB_INC;
                n_ret    = S_EM_START;
                n_state  = S_WRITE;
            end
            S_EM_START: begin
                c_cmd.op = OP_EM_START;
                n_state  = S_EM_RD;
            end
            S_EM_RD: begin
                c_cmd.op = OP_EM_RD;
                n_state  = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (i_status.out_free) begin
                    c_cmd.op = OP_EM_OUT;
                    n_state  = i_status.emit_last ? S_LOAD : S_EM_RD;
                end
            end
            S_DROP: begin
                if (i_status.out_free) begin
                    c_cmd.op      = OP_DROP;
                    c_cmd.verdict = r_dv;
                    n_state       = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // hold state and the input stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_ret      <= S_LOAD;
            r_dv       <= VERDICT_FWD;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_dv       <= n_dv;
            r_in_stall <= (n_state != S_LOAD);
        end
    end

    assign o_cmd      = c_cmd;
    assign o_in_stall = r_in_stall;
endmodule

// ===== design/iphu_dpath.sv =====
// Datapath: header store, option fields, write jobs, checksum and result register.
module iphu_dpath #(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iphu_pkg::t_cmd    i_cmd,
    output iphu_pkg::t_status o_status,
    input  logic [7:0]        i_header_byte,
    input  logic              i_is_broadcast,
    input  logic              i_fix_source_flag,
    input  logic [26:0]       i_time_of_day_ms,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_is_last_out,
    output logic [1:0]        o_verdict,
    output logic              o_source_fix_done
);
    import iphu_pkg::*;

    localparam logic [5:0] MAX_CNT = 6'(MAX_HEADER_BYTES);

    // configuration
    logic [31:0] r_router;
    logic        r_drop_bc_en, r_opt_en, r_fix_en, r_ttl_en, r_ck_en;

    // capture state
    logic [5:0]  r_count, r_n;
    logic [1:0]  r_flags;
    logic [26:0] r_time;

    // processing state
    logic [RAM_DEPTH-1:0] r_mask;
    logic        r_rd_ok;
    logic [5:0]  r_hlen, r_oi;
    logic [7:0]  r_type, r_xlen, r_ptr, r_ofl;
    logic [5:0]  r_wbase, r_fin_addr;
    logic [63:0] r_wdata;
    logic [3:0]  r_wlen, r_wk;
    logic        r_fin_pend;
    logic [7:0]  r_fin_val;
    logic [5:0]  r_rbase, r_seq_len, r_k, r_ek;
    logic [31:0] r_word;
    logic [15:0] r_sum;
    logic        r_changed, r_fixed;

    // result register
    logic        r_out_valid, r_out_last, r_out_fix;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_verdict;

    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_q, rdata;
    logic              rd_ok_next;
    logic [26:0]       ms;
    logic [5:0]        oi_p, seq_pos;
    logic [8:0]        ptr9, xlen9;
    logic [7:0]        ck_byte;
    logic [15:0]       ck_val;
    logic [16:0]       ck_t;
    logic [16:0]       inc_s, inc_t;
    logic              out_free;

    iphu_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    // positions never written in this packet read as zero
    assign rdata = r_rd_ok ? ram_q : 8'h00;

    assign ms      = (r_time >= DAY_MS) ? (r_time - DAY_MS) : r_time;
    assign oi_p    = r_oi + r_ptr[5:0] - 6'd1;
    assign seq_pos = r_rbase + r_k;
    assign ptr9    = {1'b0, r_ptr};
    assign xlen9   = {1'b0, r_xlen};
    assign out_free = !r_out_valid || !i_out_stall;

    // one's complement accumulate, checksum field counts as zero
    assign ck_byte = (seq_pos == POS_CSUM || seq_pos == POS_CSUM + 6'd1) ? 8'h00 : rdata;
    assign ck_val  = r_k[0] ? {8'h00, ck_byte} : {ck_byte, 8'h00};
    assign ck_t    = {1'b0, r_sum} + {1'b0, ck_val};

    // incremental update for TTL minus one
    assign inc_s = {1'b0, ~r_word[15:0]} + {1'b0, TTL_CSUM_ADJ};
    assign inc_t = inc_s + {16'h0000, inc_s[16]};

    // read address select
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (i_cmd.op)
            OP_BEGIN:    begin ram_re = 1'b1; ram_raddr = '0;             end
            OP_RD_TYPE:  begin ram_re = 1'b1; ram_raddr = r_oi;           end
            OP_GET_TYPE: begin ram_re = 1'b1; ram_raddr = r_oi + 6'd1;    end
            OP_GET_LEN:  begin ram_re = 1'b1; ram_raddr = r_oi + 6'd2;    end
            OP_GET_PTR:  begin ram_re = 1'b1; ram_raddr = r_oi + 6'd3;    end
            OP_SEQ_RD:   begin ram_re = 1'b1; ram_raddr = seq_pos;        end
            OP_EM_RD:    begin ram_re = 1'b1; ram_raddr = r_ek;           end
            default:     begin ram_re = 1'b0; ram_raddr = '0;             end
        endcase
        rd_ok_next = (i_cmd.op == OP_BEGIN) ? 1'b1 :
                     ((ram_raddr < r_n) || r_mask[ram_raddr]);
    end

    // write address select
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (i_cmd.op == OP_LOAD) begin
            ram_we    = (r_count < MAX_CNT);
            ram_waddr = r_count;
            ram_wdata = i_header_byte;
        end else if (i_cmd.op == OP_WR) begin
            ram_we = 1'b1;
            if (r_wk != r_wlen) begin
                ram_waddr = r_wbase + {2'b00, r_wk};
                ram_wdata = r_wdata[63:56];
            end else begin
                ram_waddr = r_fin_addr;
                ram_wdata = r_fin_val;
            end
        end
    end

    // configuration, capture counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_router     <= '0;
            r_drop_bc_en <= 1'b0;
            r_opt_en     <= 1'b0;
            r_fix_en     <= 1'b0;
            r_ttl_en     <= 1'b0;
            r_ck_en      <= 1'b1;
            r_count      <= '0;
            r_flags      <= '0;
            r_time       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROUTER:   r_router     <= i_cfg_data;
                    CFG_DROP_BC:  r_drop_bc_en <= i_cfg_data[0];
                    CFG_OPT_EN:   r_opt_en     <= i_cfg_data[0];
                    CFG_FIX_EN:   r_fix_en     <= i_cfg_data[0];
                    CFG_TTL_EN:   r_ttl_en     <= i_cfg_data[0];
                    CFG_CKSUM_EN: r_ck_en      <= i_cfg_data[0];
                    default:      r_router     <= r_router;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                if (r_count == '0) begin
                    r_flags <= {i_fix_source_flag, i_is_broadcast};
                    r_time  <= i_time_of_day_ms;
                end
                if (r_count < MAX_CNT) r_count <= r_count + 6'd1;
            end else if (i_cmd.op == OP_BEGIN) begin
                r_count <= '0;
            end else if (i_cmd.op == OP_JOB_FIX) begin
                r_flags[1] <= 1'b0;
            end
            if (i_cmd.op == OP_EM_OUT || i_cmd.op == OP_DROP) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // processing registers
    always_ff @(posedge i_clk) begin
        if (ram_re) r_rd_ok <= rd_ok_next;
        unique case (i_cmd.op)
            OP_BEGIN: begin
                r_n       <= r_count;
                r_mask    <= '0;
                r_changed <= 1'b0;
                r_fixed   <= 1'b0;
            end
            OP_HLEN: begin
                r_hlen <= {rdata[3:0], 2'b00};
                r_oi   <= HDR_MIN;
            end
            OP_GET_TYPE:  r_type <= rdata;
            OP_NOOP_STEP: r_oi   <= r_oi + 6'd1;
            OP_GET_LEN:   r_xlen <= rdata;
            OP_NEXT_OPT:  r_oi   <= r_oi + r_xlen[5:0];
            OP_GET_PTR:   r_ptr  <= rdata;
            OP_GET_OFL:   r_ofl  <= rdata;
            OP_JOB_ROUTE: begin
                r_wbase    <= oi_p;
                r_wdata    <= {r_router, 32'h0};
                r_wlen     <= 4'd4;
                r_wk       <= '0;
                r_fin_pend <= 1'b1;
                r_fin_addr <= r_oi + 6'd2;
                r_fin_val  <= r_ptr + 8'd4;
                r_changed  <= 1'b1;
            end
            OP_JOB_TS0: begin
                r_wbase    <= oi_p;
                r_wdata    <= {5'b0, ms, 32'h0};
                r_wlen     <= 4'd4;
                r_wk       <= '0;
                r_fin_pend <= 1'b1;
                r_fin_addr <= r_oi + 6'd2;
                r_fin_val  <= r_ptr + 8'd4;
                r_changed  <= 1'b1;
            end
            OP_JOB_TS1: begin
                r_wbase    <= oi_p;
                r_wdata    <= {r_router, 5'b0, ms};
                r_wlen     <= 4'd8;
                r_wk       <= '0;
                r_fin_pend <= 1'b1;
                r_fin_addr <= r_oi + 6'd2;
                r_fin_val  <= r_ptr + 8'd8;
                r_changed  <= 1'b1;
            end
            OP_JOB_TS3: begin
                r_wbase    <= oi_p + 6'd4;
                r_wdata    <= {5'b0, ms, 32'h0};
                r_wlen     <= 4'd4;
                r_wk       <= '0;
                r_fin_pend <= 1'b1;
                r_fin_addr <= r_oi + 6'd2;
                r_fin_val  <= r_ptr + 8'd8;
                r_changed  <= 1'b1;
            end
            OP_JOB_OFL: begin
                r_wlen     <= '0;
                r_wk       <= '0;
                r_fin_pend <= 1'b1;
                r_fin_addr <= r_oi + 6'd3;
                r_fin_val  <= {r_ofl[7:4] + 4'd1, r_ofl[3:0]};
                r_changed  <= 1'b1;
            end
            OP_JOB_FIX: begin
                r_wbase    <= POS_SRC;
                r_wdata    <= {r_router, 32'h0};
                r_wlen     <= 4'd4;
                r_wk       <= '0;
                r_fin_pend <= 1'b0;
                r_changed  <= 1'b1;
                r_fixed    <= 1'b1;
            end
            OP_JOB_CK: begin
                r_wbase    <= POS_CSUM;
                r_wdata    <= {~r_sum, 48'h0};
                r_wlen     <= 4'd2;
                r_wk       <= '0;
                r_fin_pend <= 1'b0;
            end
            OP_JOB_TTL: begin
                r_wbase    <= POS_TTL;
                r_wdata    <= {r_word[7:0] - 8'd1, 56'h0};
                r_wlen     <= 4'd1;
                r_wk       <= '0;
                r_fin_pend <= 1'b0;
            end
            OP_JOB_INC: begin
                r_wbase    <= POS_CSUM;
                r_wdata    <= {~inc_t[15:0], 48'h0};
                r_wlen     <= 4'd2;
                r_wk       <= '0;
                r_fin_pend <= 1'b0;
            end
            OP_WR: begin
                r_mask[ram_waddr] <= 1'b1;
                if (r_wk != r_wlen) begin
                    r_wk    <= r_wk + 4'd1;
                    r_wdata <= {r_wdata[55:0], 8'h00};
                end else begin
                    r_fin_pend <= 1'b0;
                end
            end
            OP_SEQ_CMP: begin
                r_rbase   <= oi_p;
                r_seq_len <= 6'd4;
                r_k       <= '0;
                r_word    <= '0;
            end
            OP_SEQ_CK: begin
                r_rbase   <= '0;
                r_seq_len <= r_hlen;
                r_k       <= '0;
                r_sum     <= '0;
            end
            OP_SEQ_TTL: begin
                r_rbase   <= POS_TTL;
                r_seq_len <= 6'd1;
                r_k       <= '0;
                r_word    <= '0;
            end
            OP_SEQ_OLD: begin
                r_rbase   <= POS_CSUM;
                r_seq_len <= 6'd2;
                r_k       <= '0;
                r_word    <= '0;
            end
            OP_SEQ_GET: begin
                r_word <= {r_word[23:0], rdata};
                r_sum  <= ck_t[15:0] + {15'h0000, ck_t[16]};
                r_k    <= r_k + 6'd1;
            end
            OP_EM_START: r_ek <= '0;
            OP_EM_OUT: begin
                r_out_byte    <= rdata;
                r_out_last    <= (r_ek + 6'd1 == r_n);
                r_out_verdict <= VERDICT_FWD;
                r_out_fix     <= r_fixed;
                r_ek          <= r_ek + 6'd1;
            end
            OP_DROP: begin
                r_out_byte    <= 8'h00;
                r_out_last    <= 1'b1;
                r_out_verdict <= i_cmd.verdict;
                r_out_fix     <= 1'b0;
            end
            default: r_ek <= r_ek;
        endcase
    end

    // status for the controller
    always_comb begin
        o_status.drop_bc    = r_drop_bc_en && r_flags[0];
        o_status.opt_go     = r_opt_en && (r_hlen > HDR_MIN);
        o_status.oi_end     = (r_oi >= r_hlen);
        o_status.is_noop    = (r_type == OPT_NOOP);
        o_status.is_end     = (r_type == OPT_END);
        o_status.is_route   = (r_type == OPT_ROUTE);
        o_status.is_stamp   = (r_type == OPT_STAMP);
        o_status.len_bad    = (r_xlen < 8'd2) ||
                              ({3'b000, r_oi} + xlen9 > {3'b000, r_hlen});
        o_status.route_ok   = (r_ptr >= 8'd4) && (ptr9 + 9'd3 <= xlen9);
        o_status.route_full = (ptr9 == xlen9 + 9'd1);
        o_status.p_bad      = (r_ptr < 8'd5);
        o_status.flg        = r_ofl[3:0];
        o_status.room4      = (ptr9 + 9'd3 <= xlen9);
        o_status.room8      = (ptr9 + 9'd7 <= xlen9);
        o_status.ofl_ok     = (r_ofl[7:4] != OFLW_MAX);
        o_status.cmp_eq     = (r_word == r_router);
        o_status.fix_go     = r_fix_en && r_flags[1];
        o_status.changed    = r_changed;
        o_status.ttl_en     = r_ttl_en;
        o_status.ttl_gt1    = (r_word[7:0] > 8'd1);
        o_status.ck_en      = r_ck_en;
        o_status.job_done   = (r_wk == r_wlen) && !r_fin_pend;
        o_status.seq_done   = (r_k == r_seq_len);
        o_status.emit_last  = (r_ek + 6'd1 == r_n);
        o_status.out_free   = out_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_is_last_out     = r_out_last;
    assign o_verdict         = r_out_verdict;
    assign o_source_fix_done = r_out_fix;
endmodule

// ===== design/ipv4_postrouting_header_update_unit.sv =====
// Top level: IPv4 post-routing header update unit.
// Load takes one header byte per cycle while the input is not stalled; bytes past MAX_HEADER_BYTES are dropped.
// Processing reads the header store with a registered read for the option walk, a full
// checksum and the TTL with its patch; each output beat is read, then registered.
// One packet at a time; input stalls after the last byte until the final beat is registered.
// Synchronous active-low reset clears control state and sets register defaults.
module ipv4_postrouting_header_update_unit #(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_header_byte,
    input  logic        i_is_last_byte,
    input  logic        i_is_broadcast,
    input  logic        i_fix_source_flag,
    input  logic [26:0] i_time_of_day_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_last_out,
    output logic [1:0]  o_verdict,
    output logic        o_source_fix_done,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import iphu_pkg::*;

    t_cmd    cmd;
    t_status status;

    iphu_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_is_last_byte(i_is_last_byte),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_in_stall    (o_in_stall)
    );

    iphu_dpath #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_header_byte    (i_header_byte),
        .i_is_broadcast   (i_is_broadcast),
        .i_fix_source_flag(i_fix_source_flag),
        .i_time_of_day_ms (i_time_of_day_ms),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_is_last_out    (o_is_last_out),
        .o_verdict        (o_verdict),
        .o_source_fix_done(o_source_fix_done)
    );
endmodule

// ===== design/iphu_checker.sv =====
// Port-level checks for the header update unit, bound to the top level.
module iphu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_is_last_out,
    input logic [1:0] o_verdict,
    input logic       o_source_fix_done
);
    import iphu_pkg::*;

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a drop beat is a lone, zeroed final beat
    a_drop_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict != VERDICT_FWD) |->
        (o_out_byte == 8'h00 && o_is_last_out && !o_source_fix_done))
        else $error("malformed drop beat");

    // input is held off while a packet is still being emitted
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_last_out) |-> o_in_stall)
        else $error("input accepted mid-emission");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_byte) &&
        $stable(o_verdict) && $stable(o_is_last_out)))
        else $error("stalled result beat changed");
endmodule

bind ipv4_postrouting_header_update_unit iphu_checker u_iphu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_byte       (o_out_byte),
    .o_is_last_out    (o_is_last_out),
    .o_verdict        (o_verdict),
    .o_source_fix_done(o_source_fix_done)
);
